// ----- src/gcsc_pkg.sv -----
// Shared types, constants and the microprogram of the coloring counter.
`default_nettype none

package gcsc_pkg;

  localparam int ROW_W = 16;
  localparam int COUNT_W = 49;
  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_MAX_COLORS = 8;
  localparam int CFG_DATA_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic REG_NUM_COLORS = 1'b0;
  localparam logic REG_NUM_VERTICES = 1'b1;

  localparam logic [3:0] NUM_COLORS_RST = 4'd3;
  localparam logic [4:0] NUM_VERTICES_RST = 5'd4;

  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE = 4'd0;
  localparam step_t ST_INIT = 4'd1;
  localparam step_t ST_TRY = 4'd2;
  localparam step_t ST_CHECK = 4'd3;
  localparam step_t ST_PUSH = 4'd4;
  localparam step_t ST_LEAF = 4'd5;
  localparam step_t ST_POP = 4'd6;
  localparam step_t ST_DEC = 4'd7;
  localparam step_t ST_EXT = 4'd8;
  localparam step_t ST_MUL = 4'd9;
  localparam step_t ST_DONE = 4'd10;
  localparam step_t ST_ONE = 4'd11;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDLE_WAIT,
    C_NS_ZERO,
    C_IS_LAST,
    C_NONE_OK,
    C_V_ZERO,
    C_EXTRA_ZERO
  } cond_t;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_ONE,
    CNT_ADD,
    CNT_MUL
  } cnt_op_t;

  typedef enum logic [1:0] {
    V_HOLD,
    V_CLEAR,
    V_INC,
    V_DEC
  } v_op_t;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stk_op_t;

  typedef enum logic [1:0] {
    EXT_HOLD,
    EXT_LOAD,
    EXT_DEC
  } ext_op_t;

  typedef struct packed {
    cond_t   cond;
    step_t   target;
    cnt_op_t cnt_op;
    v_op_t   v_op;
    stk_op_t stk_op;
    ext_op_t ext_op;
    logic    emit;
  } ucode_t;

  localparam ucode_t UC_NOP = '{
    cond: C_NEVER, target: ST_IDLE, cnt_op: CNT_HOLD, v_op: V_HOLD,
    stk_op: STK_HOLD, ext_op: EXT_HOLD, emit: 1'b0
  };

  function automatic ucode_t ucode(input step_t pc);
    ucode_t w;
    w = UC_NOP;
    unique case (pc)
      ST_IDLE: begin
        w.cond = C_IDLE_WAIT;
        w.target = ST_IDLE;
      end
      ST_INIT: begin
        w.cnt_op = CNT_CLEAR;
        w.v_op = V_CLEAR;
        w.ext_op = EXT_LOAD;
        w.cond = C_NS_ZERO;
        w.target = ST_ONE;
      end
      ST_TRY: begin
        w.cond = C_IS_LAST;
        w.target = ST_LEAF;
      end
      ST_CHECK: begin
        w.cond = C_NONE_OK;
        w.target = ST_POP;
      end
      ST_PUSH: begin
        w.stk_op = STK_PUSH;
        w.v_op = V_INC;
        w.cond = C_ALWAYS;
        w.target = ST_TRY;
      end
      ST_LEAF: begin
        w.cnt_op = CNT_ADD;
      end
      ST_POP: begin
        w.stk_op = STK_POP;
        w.cond = C_V_ZERO;
        w.target = ST_EXT;
      end
      ST_DEC: begin
        w.v_op = V_DEC;
        w.cond = C_ALWAYS;
        w.target = ST_TRY;
      end
      ST_EXT: begin
        w.cond = C_EXTRA_ZERO;
        w.target = ST_DONE;
      end
      ST_MUL: begin
        w.cnt_op = CNT_MUL;
        w.ext_op = EXT_DEC;
        w.cond = C_ALWAYS;
        w.target = ST_EXT;
      end
      ST_DONE: begin
        w.emit = 1'b1;
        w.cond = C_ALWAYS;
        w.target = ST_IDLE;
      end
      ST_ONE: begin
        w.cnt_op = CNT_ONE;
        w.cond = C_ALWAYS;
        w.target = ST_EXT;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- src/graph_coloring_solution_counter.sv -----
// Coloring counter: row store, microcoded backtracking search and result register.
//
//   channel   handshake             payload
//   row in    start / busy          row_index, row_bits, last_row
//   result    done (strobe)         solution_count, colorable
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// A row word is taken while busy is low; busy stays low between rows.
// A word with last_row set starts the search, one microcode step per cycle: set-up;
// per vertex, try, check and push the lowest allowed color, or pop and step back once
// none is left; at the last vertex, add the allowed colors to the count; per vertex
// beyond the row width, multiply the count by the number of colors; then emit.
// done pulses for one cycle after the search; the receiver cannot stall. Synchronous
// reset clears the sequencer, color stack, count and done, and presets the config.
`default_nettype none

module graph_coloring_solution_counter
  import gcsc_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_COLORS = DEF_MAX_COLORS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [3:0]            row_index,
  input  wire logic [ROW_W-1:0]      row_bits,
  input  wire logic                  last_row,
  output logic                       done,
  output logic [COUNT_W-1:0]         solution_count,
  output logic                       colorable,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SEARCH_V = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
  localparam int SIW = $clog2(SEARCH_V);
  localparam int VW = $clog2(MAX_VERTICES + 1);
  localparam int CLW = $clog2(MAX_COLORS + 1);
  localparam int PW = COUNT_W + CLW;

  logic [3:0] num_colors;
  logic [4:0] num_vertices;

  logic [ROW_W-1:0] adj [SEARCH_V];
  logic [CLW-1:0]   stack [SEARCH_V];
  logic [SIW-1:0]   v;
  logic [VW-1:0]    extra;
  logic [COUNT_W-1:0] count;
  step_t pc;
  step_t pc_next;
  ucode_t uw;

  logic           accept;
  logic [5:0]     nv6;
  logic [VW-1:0]  n_eff;
  logic [VW-1:0]  ns;
  logic [CLW-1:0] m_eff;
  logic [MAX_COLORS-1:0] forbid;
  logic [MAX_COLORS-1:0] allowed;
  logic [CLW-1:0] low_color;
  logic [CLW-1:0] n_ok;
  logic [COUNT_W:0] sum;
  logic [PW-1:0]  prod;
  logic           cond_true;

  assign cfg_ready = 1'b1;
  assign busy = (pc != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_colors <= NUM_COLORS_RST;
      num_vertices <= NUM_VERTICES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_COLORS:   num_colors <= cfg_data[3:0];
        REG_NUM_VERTICES: num_vertices <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ({1'b0, row_index} < 5'(SEARCH_V))) begin
      adj[SIW'(row_index)] <= row_bits;
    end
  end

  always_comb begin
    nv6 = {1'b0, num_vertices};
    n_eff = (nv6 > 6'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : VW'(nv6);
    ns = (n_eff > VW'(SEARCH_V)) ? VW'(SEARCH_V) : n_eff;
    m_eff = ({1'b0, num_colors} > 5'(MAX_COLORS)) ? CLW'(MAX_COLORS)
                                                  : num_colors[CLW-1:0];
  end

  always_comb begin
    forbid = '0;
    for (int i = 0; i < SEARCH_V; i++) begin
      for (int k = 0; k < MAX_COLORS; k++) begin
        if ((SIW'(i) < v) && adj[v][i] && (stack[i] == CLW'(k + 1))) begin
          forbid[k] = 1'b1;
        end
      end
    end
    for (int k = 0; k < MAX_COLORS; k++) begin
      allowed[k] = (CLW'(k + 1) <= m_eff) && !forbid[k] && (CLW'(k + 1) > stack[v]);
    end
    low_color = '0;
    for (int k = MAX_COLORS - 1; k >= 0; k--) begin
      if (allowed[k]) begin
        low_color = CLW'(k + 1);
      end
    end
    n_ok = CLW'($countones(allowed));
  end

  always_comb begin
    sum = {1'b0, count} + (COUNT_W + 1)'(n_ok);
    prod = PW'(count) * PW'(m_eff);
  end

  always_comb begin
    uw = ucode(pc);
    unique case (uw.cond)
      C_NEVER:      cond_true = 1'b0;
      C_ALWAYS:     cond_true = 1'b1;
      C_IDLE_WAIT:  cond_true = !(start && last_row);
      C_NS_ZERO:    cond_true = (ns == '0);
      C_IS_LAST:    cond_true = (VW'(v) == ns - VW'(1));
      C_NONE_OK:    cond_true = (allowed == '0);
      C_V_ZERO:     cond_true = (v == '0);
      C_EXTRA_ZERO: cond_true = (extra == '0);
    endcase
    pc_next = cond_true ? uw.target : pc + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      for (int i = 0; i < SEARCH_V; i++) begin
        stack[i] <= '0;
      end
    end else begin
      unique case (uw.stk_op)
        STK_PUSH: stack[v] <= low_color;
        STK_POP:  stack[v] <= '0;
        default: ;
      endcase
      unique case (uw.v_op)
        V_CLEAR: v <= '0;
        V_INC:   v <= v + SIW'(1);
        V_DEC:   v <= v - SIW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      extra <= '0;
    end else begin
      unique case (uw.cnt_op)
        CNT_CLEAR: count <= '0;
        CNT_ONE:   count <= COUNT_W'(1);
        CNT_ADD:   count <= (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
        CNT_MUL:   count <= (prod > PW'(COUNT_MAX)) ? COUNT_MAX : prod[COUNT_W-1:0];
        default: ;
      endcase
      unique case (uw.ext_op)
        EXT_LOAD: extra <= n_eff - ns;
        EXT_DEC:  extra <= extra - VW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= uw.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.emit) begin
      solution_count <= count;
      colorable <= (count != '0);
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/graph_coloring_solution_counter_tb.sv -----
// Self-checking regression for the graph coloring solution counter.
`default_nettype none

module graph_coloring_solution_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gcsc_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES = 12;
  localparam int WORDS_PER_PHASE = 150;
  localparam longint SEARCH_COST_CAP = 1024;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               colorable;
  } coloring_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [3:0]            row_index = '0;
  logic [ROW_W-1:0]      row_bits = '0;
  logic                  last_row = 1'b0;
  logic                  done;
  logic [COUNT_W-1:0]    solution_count;
  logic                  colorable;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [ROW_W-1:0]      adj_rows [16];
  logic [15:0]           rows_loaded = '0;
  logic [3:0]            cfg_colors = NUM_COLORS_RST;
  logic [4:0]            cfg_vertices = NUM_VERTICES_RST;
  coloring_result_t      pending_counts [$];

  int sender_idle_pct = 0;
  int words_sent = 0;
  int searches_checked = 0;
  int reg_writes = 0;
  int mismatches = 0;

  graph_coloring_solution_counter dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .row_index(row_index),
    .row_bits(row_bits),
    .last_row(last_row),
    .done(done),
    .solution_count(solution_count),
    .colorable(colorable),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int colors_in_use(input logic [3:0] c);
    return (c > DEF_MAX_COLORS) ? DEF_MAX_COLORS : int'(c);
  endfunction

  function automatic int vertices_in_use(input logic [4:0] v);
    return (v > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : int'(v);
  endfunction

  // Vertex-ordered backtracking over the stored rows; vertex v checks bit i of its row, i < v.
  function automatic logic [COUNT_W-1:0] count_colorings(input int n, input int m);
    int     hue [16];
    int     v;
    bit     ok;
    longint total;
    if (n == 0) return 1;
    if (m == 0) return 0;
    for (int i = 0; i < 16; i++) hue[i] = 0;
    v = 0;
    total = 0;
    while (v >= 0) begin
      hue[v]++;
      if (hue[v] > m) begin
        hue[v] = 0;
        v--;
      end else begin
        ok = 1'b1;
        for (int i = 0; i < v; i++)
          if (adj_rows[v][i] && hue[i] == hue[v]) ok = 1'b0;
        if (ok) begin
          if (v == n - 1) total++;
          else v++;
        end
      end
    end
    if (total > longint'(COUNT_MAX)) total = longint'(COUNT_MAX);
    return total[COUNT_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] pick_row_bits();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return ROW_W'($urandom() & $urandom());
      3: return ROW_W'($urandom());
      4: return ROW_W'($urandom() | $urandom());
      default: return ROW_W'($urandom() & $urandom() & $urandom());
    endcase
  endfunction

  function automatic bit search_affordable(input int n, input int m);
    longint c;
    c = 1;
    for (int i = 0; i < n; i++) begin
      c = c * m;
      if (c > SEARCH_COST_CAP) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_row(input logic [3:0] idx, input logic [ROW_W-1:0] bits, input logic last);
    coloring_result_t want;
    logic [COUNT_W-1:0] cnt;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    row_index <= idx;
    row_bits <= bits;
    last_row <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    adj_rows[idx] = bits;
    rows_loaded[idx] = 1'b1;
    words_sent++;
    if (last) begin
      cnt = count_colorings(vertices_in_use(cfg_vertices), colors_in_use(cfg_colors));
      want.count = cnt;
      want.colorable = (cnt != 0);
      pending_counts.push_back(want);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_NUM_COLORS) cfg_colors = data[3:0];
    else cfg_vertices = data[4:0];
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [4:0] colors_data, input logic [4:0] vertices_data);
    hold_until_drained();
    if ($urandom_range(1)) begin
      write_reg(REG_NUM_COLORS, colors_data);
      write_reg(REG_NUM_VERTICES, vertices_data);
    end else begin
      write_reg(REG_NUM_VERTICES, vertices_data);
      write_reg(REG_NUM_COLORS, colors_data);
    end
  endtask

  task automatic run_graph_search(input int n);
    int order [16];
    int k;
    int j;
    int tmp;
    logic [15:0] need;
    need = '0;
    for (int i = 0; i < n; i++) need[i] = 1'b1;
    if (n == 0) begin
      send_row(4'($urandom_range(15)), pick_row_bits(), 1'b1);
    end else if ((rows_loaded & need) != need) begin
      for (int i = 0; i < 16; i++) order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < n; i++) send_row(4'(order[i]), pick_row_bits(), i == n - 1);
    end else begin
      k = $urandom_range(4, 1);
      for (int i = 0; i < k; i++)
        send_row(4'($urandom_range(15)), pick_row_bits(), i == k - 1);
    end
  endtask

  // Reset values of both registers; self loop, asymmetric and out-of-graph row bits.
  task automatic test_reset_defaults();
    send_row(4'd0, 16'h0003, 1'b0);
    send_row(4'd1, 16'h0000, 1'b0);
    send_row(4'd2, 16'hFFF3, 1'b0);
    send_row(4'd3, 16'h0014, 1'b1);
  endtask

  task automatic test_zero_sizes();
    set_config(5'd3, 5'd0);
    send_row(4'd15, 16'hFFFF, 1'b1);
    set_config(5'd0, 5'd0);
    send_row(4'd7, 16'h0000, 1'b1);
    set_config(5'd16, 5'd3);
    send_row(4'd0, 16'h0000, 1'b1);
  endtask

  task automatic test_color_limit();
    set_config(5'h1F, 5'd3);
    send_row(4'd2, 16'h0000, 1'b1);
    set_config(5'd8, 5'd4);
    send_row(4'd3, 16'h0000, 1'b1);
  endtask

  task automatic test_vertex_limit();
    set_config(5'd2, 5'd16);
    send_row(4'd0, 16'hFFFF, 1'b0);
    for (int j = 1; j < 16; j++)
      send_row(4'(j), (16'h1 << (j - 1)) | (16'hFFFF << j), j == 15);
    set_config(5'h11, 5'h1F);
    send_row(4'd15, 16'h8000, 1'b1);
  endtask

  task automatic test_random_graphs();
    logic [4:0] colors_data;
    logic [4:0] vertices_data;
    int n;
    int phase_start;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 3)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 46;
        default: sender_idle_pct = 29;
      endcase
      do begin
        colors_data = 5'($urandom_range(31));
        vertices_data = 5'($urandom_range(31));
      end while (!search_affordable(vertices_in_use(vertices_data),
                                    colors_in_use(colors_data[3:0])));
      set_config(colors_data, vertices_data);
      n = vertices_in_use(cfg_vertices);
      phase_start = words_sent;
      while (words_sent - phase_start < WORDS_PER_PHASE) begin
        if ($urandom_range(99) < 15)
          send_row(4'($urandom_range(15)), pick_row_bits(), 1'b0);
        else run_graph_search(n);
        if ($urandom_range(19) == 0) hold_until_drained();
      end
    end
  endtask

  always @(posedge clk) begin : check_result
    coloring_result_t want;
    if (!rst && done) begin
      if (pending_counts.size() == 0) begin
        flag_mismatch("result word with no search pending", 64'(solution_count), 0);
      end else begin
        want = pending_counts.pop_front();
        if (solution_count !== want.count)
          flag_mismatch("solution_count", 64'(solution_count), 64'(want.count));
        if (colorable !== want.colorable)
          flag_mismatch("colorable", 64'(colorable), 64'(want.colorable));
        searches_checked++;
      end
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) adj_rows[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_zero_sizes();
    test_color_limit();
    test_vertex_limit();
    test_random_graphs();
    hold_until_drained();
    $display("%0d row words, %0d search results checked, %0d register writes",
             words_sent, searches_checked, reg_writes);
    $display("graphs of 0 to 16 vertices, 0 to 15 colors, sender idle 0/29/46 percent");
    if (mismatches == 0) begin
      $display("graph_coloring_solution_counter regression: pass");
    end else begin
      $display("graph_coloring_solution_counter regression: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("timeout with %0d results pending", pending_counts.size());
    $display("graph_coloring_solution_counter regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ----- graph_coloring_solution_counter.f -----
src/gcsc_pkg.sv
src/graph_coloring_solution_counter.sv
tb/sv/graph_coloring_solution_counter_tb.sv
